[design/gfa_pkg.sv]
// Shared types, constants and helper functions for the grid rectangle allocator.
// Used by the controller, the datapath, the top level and the port checker.
package gfa_pkg;

  // Grid size limits and derived widths.
  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 16;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = ROW_W + 1;
  localparam int DIM_W    = 5;

  // Request codes.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_PLACE_FIT = 2'd0;
  localparam opcode_t OP_PLACE_AT  = 2'd1;
  localparam opcode_t OP_RELEASE   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // One request.
  typedef struct packed {
    opcode_t            opcode;
    logic               item_valid;
    logic [DIM_W-1:0]   item_width;
    logic [DIM_W-1:0]   item_height;
    logic [COL_W-1:0]   pos_col;
    logic [ROW_W-1:0]   pos_row;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic               success;
    logic [COL_W-1:0]   placed_col;
    logic [ROW_W-1:0]   placed_row;
  } out_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the request
    logic pt_init;     // start the check at the requested point
    logic pt_step;     // fold one row into the point check
    logic scan_init;   // start the first-fit scan at row zero
    logic scan_step;   // advance the scan by one row
    logic fill_point;  // target the requested point for the fill
    logic fill_scan;   // target the scan hit for the fill
    logic fill_set;    // fill marks cells occupied rather than free
    logic fill_step;   // write one row of the fill
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t opcode;
    logic    item_valid;
    logic    geom_ok;      // nonzero width and height
    logic    pt_inside;    // rectangle at the point lies inside the grid
    logic    pt_conflict;  // an occupied cell seen under the point rectangle
    logic    pt_last;      // current row is the bottom row of the point rectangle
    logic    scan_done;    // scan ran past the last grid row
    logic    scan_hit;     // a fit ends at the current scan row
    logic    fill_last;    // current row is the bottom row of the fill
  } status_t;

  // Mask of w bits starting at column c.
  function automatic logic [MAX_COLS-1:0] span_mask(input logic [COL_W:0] c,
                                                    input logic [DIM_W-1:0] w);
    logic [MAX_COLS-1:0] m;
    logic [DIM_W+1:0]    lo;
    logic [DIM_W+1:0]    hi;
    lo = (DIM_W+2)'(c);
    hi = lo + (DIM_W+2)'(w);
    for (int i = 0; i < MAX_COLS; i++) begin
      m[i] = ((DIM_W+2)'(i) >= lo) && ((DIM_W+2)'(i) < hi);
    end
    return m;
  endfunction

endpackage

[design/gfa_ctrl.sv]
// Controller state machine of the grid rectangle allocator.
// Depends on gfa_pkg for the command and status structs and request codes.
module gfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  gfa_pkg::status_t status,
  output gfa_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_strobe
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PCHK,
    S_SCAN,
    S_FILL,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   strobe_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.item_valid || !status.geom_ok) begin
          state_nxt = S_RESP;
        end else begin
          case (status.opcode)
            gfa_pkg::OP_PLACE_FIT: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
            gfa_pkg::OP_PLACE_AT: begin
              if (status.pt_inside) begin
                cmd.pt_init = 1'b1;
                state_nxt   = S_PCHK;
              end else begin
                cmd.scan_init = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            gfa_pkg::OP_RELEASE: begin
              if (status.pt_inside) begin
                cmd.fill_point = 1'b1;
                cmd.fill_set   = 1'b0;
                state_nxt      = S_FILL;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_PCHK: begin
        if (status.pt_conflict) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else if (status.pt_last) begin
          cmd.fill_point = 1'b1;
          cmd.fill_set   = 1'b1;
          state_nxt      = S_FILL;
        end else begin
          cmd.pt_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_RESP;
        end else if (status.scan_hit) begin
          cmd.fill_scan = 1'b1;
          cmd.fill_set  = 1'b1;
          state_nxt     = S_FILL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= (state_nxt != S_IDLE);
      strobe_r <= (state_nxt == S_RESP);
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

[design/gfa_datapath.sv]
// Datapath of the grid rectangle allocator: occupancy bitmap, configuration,
// row pointer, point check, column run counters for first fit, and the fill.
// Depends on gfa_pkg for types, constants and span_mask.
module gfa_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gfa_pkg::in_item_t                 in_item,
  input  gfa_pkg::cmd_t                     cmd,
  input  logic                              cfg_we,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output gfa_pkg::status_t                  status,
  output gfa_pkg::out_result_t              out_result
);

  localparam int NC = gfa_pkg::MAX_COLS;
  localparam int NR = gfa_pkg::MAX_ROWS;
  localparam int CW = gfa_pkg::COL_W;
  localparam int RW = gfa_pkg::ROW_W;
  localparam int KW = gfa_pkg::CNT_W;
  localparam int DW = gfa_pkg::DIM_W;

  gfa_pkg::in_item_t item_r;
  logic [DW-1:0]     grid_w_r;
  logic [DW-1:0]     grid_h_r;
  logic [NC-1:0]     occ_r [NR];
  logic [KW-1:0]     ptr_r;
  logic [NC-1:0]     acc_r;
  logic [KW-1:0]     cnt_r [NC];
  logic [CW-1:0]     tgt_col_r;
  logic [RW-1:0]     tgt_row_r;
  logic              ok_r;
  logic              fill_set_r;

  logic [DW-1:0]     eff_cols;
  logic [DW-1:0]     eff_rows;
  logic [NC-1:0]     row_cur;
  logic [NC-1:0]     pt_mask;
  logic [NC-1:0]     fill_mask;
  logic [KW-1:0]     new_cnt [NC];
  logic [NC-1:0]     ok_vec;
  logic [NC-1:0]     fit_vec;
  logic [CW-1:0]     hit_col;
  logic [KW-1:0]     hit_row;

  // Grid size clipped to the bitmap.
  assign eff_cols = (grid_w_r > DW'(NC)) ? DW'(NC) : grid_w_r;
  assign eff_rows = (grid_h_r > DW'(NR)) ? DW'(NR) : grid_h_r;

  assign row_cur   = occ_r[ptr_r[RW-1:0]];
  assign pt_mask   = gfa_pkg::span_mask({1'b0, item_r.pos_col}, item_r.item_width);
  assign fill_mask = gfa_pkg::span_mask({1'b0, tgt_col_r}, item_r.item_width);

  // Free-run length per column including the current row, and the columns
  // where a rectangle of the item height ends at the current row.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      new_cnt[c] = row_cur[c] ? '0 : cnt_r[c] + KW'(1);
      ok_vec[c]  = new_cnt[c] >= item_r.item_height;
    end
  end

  // Candidate columns whose whole span is free and inside the grid.
  always_comb begin
    logic [NC-1:0] m;
    for (int c = 0; c < NC; c++) begin
      m          = gfa_pkg::span_mask((CW+1)'(c), item_r.item_width);
      fit_vec[c] = (((DW+1)'(c) + (DW+1)'(item_r.item_width)) <= (DW+1)'(eff_cols))
                   && ((ok_vec & m) == m);
    end
  end

  // Lowest fitting column.
  always_comb begin
    hit_col = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (fit_vec[c]) begin
        hit_col = CW'(c);
      end
    end
  end

  assign hit_row = ptr_r + KW'(1) - item_r.item_height;

  // Status toward the controller.
  always_comb begin
    status.opcode      = item_r.opcode;
    status.item_valid  = item_r.item_valid;
    status.geom_ok     = (item_r.item_width != '0) && (item_r.item_height != '0);
    status.pt_inside   = status.geom_ok
      && (((DW+1)'(item_r.pos_col) + (DW+1)'(item_r.item_width)) <= (DW+1)'(eff_cols))
      && (((DW+1)'(item_r.pos_row) + (DW+1)'(item_r.item_height)) <= (DW+1)'(eff_rows));
    status.pt_conflict = |((acc_r | row_cur) & pt_mask);
    status.pt_last     = ((DW+1)'(ptr_r) + (DW+1)'(1))
                         == ((DW+1)'(item_r.pos_row) + (DW+1)'(item_r.item_height));
    status.scan_done   = (DW'(ptr_r) >= eff_rows);
    status.scan_hit    = |fit_vec;
    status.fill_last   = ((DW+1)'(ptr_r) + (DW+1)'(1))
                         == ((DW+1)'(tgt_row_r) + (DW+1)'(item_r.item_height));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= DW'(1);
      grid_h_r <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfa_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_data;
        gfa_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Occupancy bitmap, one row written per fill cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NR; r++) begin
        occ_r[r] <= '0;
      end
    end else if (cmd.fill_step) begin
      if (fill_set_r) begin
        occ_r[ptr_r[RW-1:0]] <= row_cur | fill_mask;
      end else begin
        occ_r[ptr_r[RW-1:0]] <= row_cur & ~fill_mask;
      end
    end
  end

  // Result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (cmd.load) begin
      ok_r <= 1'b0;
    end else if (cmd.fill_point || cmd.fill_scan) begin
      ok_r <= 1'b1;
    end
  end

  // Request, pointer, accumulators and fill target.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.pt_init) begin
      ptr_r <= KW'(item_r.pos_row);
      acc_r <= '0;
    end else if (cmd.pt_step) begin
      ptr_r <= ptr_r + KW'(1);
      acc_r <= acc_r | row_cur;
    end else if (cmd.scan_init) begin
      ptr_r <= '0;
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r + KW'(1);
    end else if (cmd.fill_point) begin
      ptr_r <= KW'(item_r.pos_row);
    end else if (cmd.fill_scan) begin
      ptr_r <= KW'(hit_row[RW-1:0]);
    end else if (cmd.fill_step) begin
      ptr_r <= ptr_r + KW'(1);
    end
    for (int c = 0; c < NC; c++) begin
      if (cmd.scan_init) begin
        cnt_r[c] <= '0;
      end else if (cmd.scan_step) begin
        cnt_r[c] <= new_cnt[c];
      end
    end
    if (cmd.fill_point) begin
      tgt_col_r  <= item_r.pos_col;
      tgt_row_r  <= item_r.pos_row;
      fill_set_r <= cmd.fill_set;
    end else if (cmd.fill_scan) begin
      tgt_col_r  <= hit_col;
      tgt_row_r  <= hit_row[RW-1:0];
      fill_set_r <= cmd.fill_set;
    end
  end

  // Result fields; position reads zero on failure.
  assign out_result.success    = ok_r;
  assign out_result.placed_col = ok_r ? tgt_col_r : '0;
  assign out_result.placed_row = ok_r ? tgt_row_r : '0;

endmodule

[design/grid_rectangle_first_fit_allocator.sv]
// Top level of the grid rectangle first-fit allocator.
// Instantiates gfa_ctrl and gfa_datapath; types come from gfa_pkg.
//
// A request is taken when start is high while busy is low; busy then stays
// high until its result has been shown. Each request yields exactly one result,
// held on out_result for the single cycle in which out_strobe is high; the
// receiver must take it then. A request is served by a row-at-a-time walk over
// the occupancy bitmap, one bitmap row per cycle: setup latches and decodes
// the request, then come a row-by-row check of a requested point, a first-fit
// scan from row zero, the writing of the placed or released rectangle, and a
// result step; an invalid item goes from setup to its result. Grid size
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, as the block does not enforce it.
// The bitmap is cleared by reset and is not touched by a resize.
module grid_rectangle_first_fit_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  gfa_pkg::in_item_t                 in_item,
  output logic                              out_strobe,
  output gfa_pkg::out_result_t              out_result,
  input  logic                              cfg_we,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  gfa_pkg::cmd_t    cmd;
  gfa_pkg::status_t status;

  // Sequencing of the checks, scan and fill.
  gfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // Bitmap and arithmetic.
  gfa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .out_result (out_result)
  );

endmodule

[design/gfa_checker.sv]
// Port-level checks for the grid rectangle allocator, bound to its top level.
// Depends on gfa_pkg for the result struct.
module gfa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input gfa_pkg::out_result_t out_result
);

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result transfer only happens while a request is outstanding.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // Exactly one result per request: busy drops right after the result.
  a_strobe_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!busy && !out_strobe))
    else $error("block still busy after its result");

  // A failed result reports the origin.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.success) |->
      (out_result.placed_col == '0 && out_result.placed_row == '0))
    else $error("failed result with nonzero position");

endmodule

bind grid_rectangle_first_fit_allocator gfa_checker u_gfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
